// ----- design/lsrc_pkg.sv -----
// ---------------------------------------------------------------------------
// lsrc_pkg: shared types and constants of the segment clipper
// Register indexes of the configuration port.
// ---------------------------------------------------------------------------
package lsrc_pkg;

  localparam int unsigned CfgIdxBits = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_A_X = 2'd0,
    CFG_A_Y = 2'd1,
    CFG_B_X = 2'd2,
    CFG_B_Y = 2'd3
  } cfg_idx_e;

endpackage

// ----- design/lsrc_div_stage.sv -----
// ---------------------------------------------------------------------------
// lsrc_div_stage: one registered restoring-division step
// Carries the remainder, divisor and quotient of one lane forward by one bit.
// ---------------------------------------------------------------------------
module lsrc_div_stage #(
  parameter int unsigned NumBits  = 18,
  parameter int unsigned QuoBits  = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [NumBits-1:0] rem_i,
  input  logic [NumBits-1:0] den_i,
  input  logic [QuoBits-1:0] quo_i,
  output logic [NumBits-1:0] rem_o,
  output logic [NumBits-1:0] den_o,
  output logic [QuoBits-1:0] quo_o
);

  logic [NumBits:0]   sh;
  logic               ge;
  logic [NumBits-1:0] rem_d, rem_q, den_q;
  logic [QuoBits-1:0] quo_d, quo_q;

  always_comb begin
    sh    = {rem_i, 1'b0};
    ge    = sh >= {1'b0, den_i};
    rem_d = ge ? NumBits'(sh - {1'b0, den_i}) : NumBits'(sh);
    quo_d = {quo_i[QuoBits-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;

endmodule

// ----- design/line_segment_rect_clipper.sv -----
// ---------------------------------------------------------------------------
// line_segment_rect_clipper: Liang-Barsky clipping of a segment to a window
// Pipelined: setup, four division lanes, u selection, multiply, output.
// ---------------------------------------------------------------------------
// One segment is accepted every cycle while the output side takes beats.
// The pipe is made of one setup stage, FRAC_BITS one-bit
// restoring division stages (four lanes side by side, one per window edge),
// a stage that folds the ratios into u1/u2, a multiply stage and the output
// register, which also takes the truncation correction. The whole pipe
// advances together and holds under back-pressure.
module line_segment_rect_clipper #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  logic [4*COORD_BITS-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y, zero pad
  output logic [((4*COORD_BITS+1+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned DB   = COORD_BITS + 2;   // difference width
  localparam int unsigned NS   = FRAC_BITS + 4;    // valid stages
  localparam int unsigned UB   = FRAC_BITS + 1;
  localparam int unsigned OutW = ((4*COORD_BITS+1+7)/8)*8;
  localparam int unsigned PB   = DB + UB;

  typedef logic signed [DB-1:0] d_t;

  // configuration
  logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsrc_pkg::CFG_A_X: ax_q <= cfg_data_i;
        lsrc_pkg::CFG_A_Y: ay_q <= cfg_data_i;
        lsrc_pkg::CFG_B_X: bx_q <= cfg_data_i;
        lsrc_pkg::CFG_B_Y: by_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic [NS-1:0] vld_q;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
  end

  // stage 0: p/q terms, per-edge class
  d_t sx, sy, ex, ey, xmin, xmax, ymin, ymax;
  d_t p [4];
  d_t q [4];
  always_comb begin
    sx = DB'(signed'(s_axis_tdata[COORD_BITS-1:0]));
    sy = DB'(signed'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]));
    ex = DB'(signed'(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]));
    ey = DB'(signed'(s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]));
    xmin = (ax_q < bx_q) ? DB'(ax_q) : DB'(bx_q);
    xmax = (ax_q < bx_q) ? DB'(bx_q) : DB'(ax_q);
    ymin = (ay_q < by_q) ? DB'(ay_q) : DB'(by_q);
    ymax = (ay_q < by_q) ? DB'(by_q) : DB'(ay_q);
    p[0] = sx - ex; p[1] = ex - sx; p[2] = sy - ey; p[3] = ey - sy;
    q[0] = sx - xmin; q[1] = xmax - sx; q[2] = sy - ymin; q[3] = ymax - sy;
  end

  // per edge: num/den for the divider, reject, and whether the ratio counts
  logic [DB-1:0] num0 [4];
  logic [DB-1:0] den0 [4];
  logic [3:0]    rej0, use0, one0;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num0[i] = '0; den0[i] = DB'(1); rej0[i] = 1'b0; use0[i] = 1'b0; one0[i] = 1'b0;
      if (p[i] < 0) begin
        num0[i] = -q[i]; den0[i] = -p[i];
        if (-q[i] > -p[i]) rej0[i] = 1'b1;
        else if (-q[i] > 0) begin
          use0[i] = 1'b1;
          if (-q[i] == -p[i]) one0[i] = 1'b1;
        end
      end else if (p[i] > 0) begin
        num0[i] = q[i]; den0[i] = p[i];
        if (q[i] < 0) rej0[i] = 1'b1;
        else if (q[i] < p[i]) use0[i] = 1'b1;
      end else if (q[i] < 0) begin
        rej0[i] = 1'b1;
      end
    end
  end

  logic [DB-1:0] rem_s [4][FRAC_BITS+1];
  logic [DB-1:0] den_s [4][FRAC_BITS+1];
  logic [FRAC_BITS-1:0] quo_s [4][FRAC_BITS+1];
  logic [3:0] rej_q [FRAC_BITS+1];
  logic [3:0] use_q [FRAC_BITS+1];
  logic [3:0] one_q [FRAC_BITS+1];
  d_t sx_q [FRAC_BITS+1];
  d_t sy_q [FRAC_BITS+1];
  d_t dx_q [FRAC_BITS+1];
  d_t dy_q [FRAC_BITS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        rem_s[i][0] <= num0[i];
        den_s[i][0] <= den0[i];
        quo_s[i][0] <= '0;
      end
      rej_q[0] <= rej0; use_q[0] <= use0; one_q[0] <= one0;
      sx_q[0] <= sx; sy_q[0] <= sy; dx_q[0] <= p[0]; dy_q[0] <= p[2];
      for (int k = 1; k <= FRAC_BITS; k++) begin
        rej_q[k] <= rej_q[k-1]; use_q[k] <= use_q[k-1]; one_q[k] <= one_q[k-1];
        sx_q[k] <= sx_q[k-1]; sy_q[k] <= sy_q[k-1];
        dx_q[k] <= dx_q[k-1]; dy_q[k] <= dy_q[k-1];
      end
    end
  end

  for (genvar gi = 0; gi < 4; gi++) begin : g_lane
    for (genvar gk = 0; gk < FRAC_BITS; gk++) begin : g_step
      lsrc_div_stage #(.NumBits(DB), .QuoBits(FRAC_BITS)) u_step (
        .clk_i (clk_i),
        .en_i  (en),
        .rem_i (rem_s[gi][gk]),
        .den_i (den_s[gi][gk]),
        .quo_i (quo_s[gi][gk]),
        .rem_o (rem_s[gi][gk+1]),
        .den_o (den_s[gi][gk+1]),
        .quo_o (quo_s[gi][gk+1])
      );
    end
  end

  // fold stage: u1 from entering edges (0,2 or 1,3 by sign), u2 from leaving
  logic [UB-1:0] u1_d, u2_d, r;
  logic          rej_d;
  logic [UB-1:0] u1_q, u2_q;
  logic          rej_f_q;
  d_t            sx_f_q, sy_f_q, dx_f_q, dy_f_q;
  always_comb begin
    u1_d = '0; u2_d = UB'(1) << FRAC_BITS; rej_d = |rej_q[FRAC_BITS];
    for (int i = 0; i < 4; i++) begin
      // num equal to den gives exactly one, past the quotient width
      r = one_q[FRAC_BITS][i] ? UB'(1) << FRAC_BITS : {1'b0, quo_s[i][FRAC_BITS]};
      if (use_q[FRAC_BITS][i]) begin
        // an entering edge has negative p
        if ((i[0] ? -dx_q[FRAC_BITS] : dx_q[FRAC_BITS]) < 0 && i < 2 ||
            (i[0] ? -dy_q[FRAC_BITS] : dy_q[FRAC_BITS]) < 0 && i >= 2) begin
          if (r > u1_d) u1_d = r;
        end else if (r < u2_d) u2_d = r;
      end
    end
    if (u1_d > u2_d) rej_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q <= u1_d; u2_q <= u2_d; rej_f_q <= rej_d;
      sx_f_q <= sx_q[FRAC_BITS]; sy_f_q <= sy_q[FRAC_BITS];
      dx_f_q <= dx_q[FRAC_BITS]; dy_f_q <= dy_q[FRAC_BITS];
    end
  end

  // multiply stage: |d| * u, one product per coordinate
  logic [PB-1:0] prod_q [4];
  logic [3:0]    neg_q;
  logic          rej_m_q;
  d_t            s_m_q [4];
  logic [DB-1:0] mag [4];
  d_t            dd [4];
  always_comb begin
    dd[0] = dx_f_q; dd[1] = dy_f_q; dd[2] = dx_f_q; dd[3] = dy_f_q;
    for (int i = 0; i < 4; i++) mag[i] = dd[i] < 0 ? DB'(-dd[i]) : DB'(dd[i]);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q[0] <= PB'(mag[0]) * PB'(u1_q);
      prod_q[1] <= PB'(mag[1]) * PB'(u1_q);
      prod_q[2] <= PB'(mag[2]) * PB'(u2_q);
      prod_q[3] <= PB'(mag[3]) * PB'(u2_q);
      for (int i = 0; i < 4; i++) neg_q[i] <= dd[i] < 0;
      s_m_q[0] <= sx_f_q; s_m_q[1] <= sy_f_q; s_m_q[2] <= sx_f_q; s_m_q[3] <= sy_f_q;
      rej_m_q <= rej_f_q;
    end
  end

  // correction stage: start -/+ integer part, truncate toward zero
  logic signed [DB:0] base [4];
  logic [COORD_BITS-1:0] res [4];
  logic [FRAC_BITS-1:0]  fr;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fr = prod_q[i][FRAC_BITS-1:0];
      if (!neg_q[i]) begin
        base[i] = (DB+1)'(s_m_q[i]) - (DB+1)'(prod_q[i][PB-1:FRAC_BITS]);
        if (fr != '0 && base[i] > 0) base[i] = base[i] - 1;
      end else begin
        base[i] = (DB+1)'(s_m_q[i]) + (DB+1)'(prod_q[i][PB-1:FRAC_BITS]);
        if (fr != '0 && base[i] < 0) base[i] = base[i] + 1;
      end
      res[i] = rej_m_q ? '1 : base[i][COORD_BITS-1:0];
    end
  end

  logic [OutW-1:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= OutW'({res[3], res[2], res[1], res[0], !rej_m_q});
    end
  end
  assign m_axis_tdata = out_q;

endmodule

// ----- design/lsrc_checker.sv -----
// ---------------------------------------------------------------------------
// lsrc_checker: port-level checks of the segment clipper
// Output stability under stall and reject encoding.
// ---------------------------------------------------------------------------
module lsrc_checker #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned OutW = 72
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready not tied to output side");

  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[4*COORD_BITS:1] == '1)
    else $error("rejected beat carries coordinates");

endmodule

bind line_segment_rect_clipper lsrc_checker #(
  .COORD_BITS(COORD_BITS), .OutW(((4*COORD_BITS+1+7)/8)*8)
) u_lsrc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

// ----- bench/tb_line_segment_rect_clipper.sv -----
// ---------------------------------------------------------------------------
// tb_line_segment_rect_clipper: self-checking bench of the segment clipper
// Drives segments through the stream input under several window settings,
// predicts each clipped result in fixed point and checks the output in order.
// ---------------------------------------------------------------------------
module tb_line_segment_rect_clipper;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 16;
  localparam int FB = 24;
  localparam int OW = ((4*CB+1+7)/8)*8;
  localparam int LATENCY = FB + 4;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [CB-1:0] ey;
    logic [CB-1:0] ex;
    logic [CB-1:0] sy;
    logic [CB-1:0] sx;
  } seg_t;

  typedef struct {
    logic          vis;
    logic [CB-1:0] csx, csy, cex, cey;
  } clip_t;

  class clip_scoreboard;
    logic signed [CB-1:0] win[4];
    clip_t pending[$];
    int errors;

    function new();
      foreach (win[i]) win[i] = '0;
      errors = 0;
    endfunction

    // floor(num * 2^FB / den), saturates at 1.0
    function longint unsigned frac_div(longint num, longint den);
      longint unsigned r;
      if (num >= den) return 64'd1 << FB;
      r = (64'(num) << FB) / 64'(den);
      return r;
    endfunction

    // trunc(s - d*u/2^FB) toward zero, exact with wide products
    function logic [CB-1:0] lerp(longint s, longint d, longint unsigned u);
      logic signed [127:0] num, ip;
      logic signed [127:0] res;
      num = 128'(s) * (128'sd1 <<< FB) - 128'(d) * $signed({64'd0, u});
      ip = num / (128'sd1 <<< FB);
      res = ip;
      return res[CB-1:0];
    endfunction

    function void note_segment(seg_t g);
      longint xmn, xmx, ymn, ymx, sx, sy, ex, ey, num, den;
      longint p[4], q[4];
      longint unsigned u1, u2, r;
      bit rej;
      clip_t c;
      xmn = win[lsrc_pkg::CFG_A_X] < win[lsrc_pkg::CFG_B_X] ?
            win[lsrc_pkg::CFG_A_X] : win[lsrc_pkg::CFG_B_X];
      xmx = win[lsrc_pkg::CFG_A_X] < win[lsrc_pkg::CFG_B_X] ?
            win[lsrc_pkg::CFG_B_X] : win[lsrc_pkg::CFG_A_X];
      ymn = win[lsrc_pkg::CFG_A_Y] < win[lsrc_pkg::CFG_B_Y] ?
            win[lsrc_pkg::CFG_A_Y] : win[lsrc_pkg::CFG_B_Y];
      ymx = win[lsrc_pkg::CFG_A_Y] < win[lsrc_pkg::CFG_B_Y] ?
            win[lsrc_pkg::CFG_B_Y] : win[lsrc_pkg::CFG_A_Y];
      sx = $signed(g.sx); sy = $signed(g.sy); ex = $signed(g.ex); ey = $signed(g.ey);
      p[0] = sx - ex; p[1] = -p[0]; p[2] = sy - ey; p[3] = -p[2];
      q[0] = sx - xmn; q[1] = xmx - sx; q[2] = sy - ymn; q[3] = ymx - sy;
      u1 = 0; u2 = 64'd1 << FB; rej = 0;
      for (int i = 0; i < 4; i++) begin
        if (p[i] < 0) begin
          num = -q[i]; den = -p[i];
          if (num > den) rej = 1;
          else if (num > 0) begin
            r = frac_div(num, den);
            if (r > u1) u1 = r;
          end
        end else if (p[i] > 0) begin
          num = q[i]; den = p[i];
          if (num < 0) rej = 1;
          else if (num < den) begin
            r = frac_div(num, den);
            if (r < u2) u2 = r;
          end
        end else if (q[i] < 0) rej = 1;
      end
      if (u1 > u2) rej = 1;
      if (rej) begin
        c.vis = 0; c.csx = '1; c.csy = '1; c.cex = '1; c.cey = '1;
      end else begin
        c.vis = 1;
        c.csx = lerp(sx, p[0], u1); c.csy = lerp(sy, p[2], u1);
        c.cex = lerp(sx, p[0], u2); c.cey = lerp(sy, p[2], u2);
      end
      pending = {pending, c};
    endfunction

    function void check_beat(logic [OW-1:0] d);
      clip_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[0] !== e.vis || d[CB:1] !== e.csx || d[2*CB:CB+1] !== e.csy
          || d[3*CB:2*CB+1] !== e.cex || d[4*CB:3*CB+1] !== e.cey) begin
        $display("%0t: mismatch expected vis=%b %h %h %h %h actual vis=%b %h %h %h %h",
                 $time, e.vis, e.csx, e.csy, e.cex, e.cey,
                 d[0], d[CB:1], d[2*CB:CB+1], d[3*CB:2*CB+1], d[4*CB:3*CB+1]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [CB-1:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [4*CB-1:0] s_axis_tdata;
  logic [OW-1:0] m_axis_tdata;

  line_segment_rect_clipper dut (.*);

  clip_scoreboard sb = new();
  int idle_pct = 34;
  bit hold_off = 0;
  int quiet = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready <= 0;
      else m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(lsrc_pkg::cfg_idx_e idx, logic [CB-1:0] v);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    if (idx <= lsrc_pkg::CFG_B_Y) sb.win[idx] = v;
    @(posedge clk_i);
  endtask

  task automatic set_window(logic [CB-1:0] ax, ay, bx, by);
    write_reg(lsrc_pkg::CFG_A_X, ax); write_reg(lsrc_pkg::CFG_A_Y, ay);
    write_reg(lsrc_pkg::CFG_B_X, bx); write_reg(lsrc_pkg::CFG_B_Y, by);
    cfg_we_i <= 0;
  endtask

  task automatic send_seg(seg_t g);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= g;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_segment(g);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic logic [CB-1:0] rnd_coord(bit near);
    if (near) return CB'($signed(($urandom_range(400)) - 200));
    return CB'($urandom);
  endfunction

  task automatic random_phase(int n, bit near);
    seg_t g;
    repeat (n) begin
      g.sx = rnd_coord(near); g.sy = rnd_coord(near);
      g.ex = rnd_coord(near); g.ey = rnd_coord(near);
      if ($urandom_range(9) == 0) begin
        g.ex = g.sx; g.ey = g.sy;
      end else if ($urandom_range(9) == 0) g.ex = g.sx;
      else if ($urandom_range(9) == 0) g.ey = g.sy;
      send_seg(g);
    end
  endtask

  localparam logic [CB-1:0] MAXC = 16'h7fff, MINC = 16'h8000;

  initial begin
    rst_ni = 0; cfg_we_i = 0; cfg_idx_i = lsrc_pkg::CFG_A_X; cfg_data_i = '0;
    s_axis_tvalid = 0; s_axis_tdata = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // zero window from reset: point on it, point off it, a crossing segment
    send_seg('{16'd0, 16'd0, 16'd0, 16'd0});
    send_seg('{16'd1, 16'd1, 16'd1, 16'd1});
    send_seg('{16'd5, 16'd5, -16'sd5, -16'sd5});
    drain();

    // reversed corners, directed cases
    set_window(16'd100, 16'd80, -16'sd100, -16'sd80);
    send_seg('{16'd0, 16'd0, 16'd0, 16'd0});          // degenerate inside
    send_seg('{16'd500, 16'd0, 16'd500, 16'd0});      // degenerate outside
    send_seg('{16'd80, 16'd100, 16'd80, 16'd100});    // degenerate on corner
    send_seg('{16'd0, -16'sd500, 16'd0, 16'sd500});   // horizontal crossing
    send_seg('{16'sd300, 16'd0, -16'sd300, 16'd0});   // vertical crossing
    send_seg('{16'sd90, -16'sd500, 16'sd90, 16'sd500}); // parallel outside
    send_seg('{16'd0, 16'd0, 16'd50, 16'd20});        // fully inside
    send_seg('{MAXC, MAXC, MINC, MINC});
    send_seg('{MINC, MINC, MAXC, MAXC});
    send_seg('{MINC, MAXC, MAXC, MINC});
    send_seg('{16'sd200, 16'sd0, 16'sd0, 16'sd300});  // misses corner
    send_seg('{16'sd120, -16'sd7, -16'sd33, 16'sd91});
    drain();

    set_window(MINC, MINC, MAXC, MAXC);
    send_seg('{MAXC, MINC, MINC, MAXC});
    send_seg('{16'hffff, 16'h0001, 16'h1234, 16'hedcb});
    random_phase(150, 0);
    drain();

    // back-pressure: receiver holds off while sender keeps offering
    set_window(-16'sd150, 16'sd120, 16'sd130, -16'sd110);
    fork
      begin
        hold_off = 1;
        repeat (3 * LATENCY) @(posedge clk_i);
        hold_off = 0;
      end
      random_phase(100, 1);
    join
    random_phase(250, 1);
    drain();

    // no idling stretch
    idle_pct = 0;
    set_window(16'sd40, 16'sd40, 16'sd40, -16'sd60);
    random_phase(200, 1);
    drain();
    idle_pct = 34;

    set_window(16'sd7, MAXC, MINC, -16'sd3);
    random_phase(200, 0);
    drain();

    set_window(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
    random_phase(300, 0);
    drain();

    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
